### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the servo pulse phase sequencer. SYNTH drops them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// clocked check, off while in reset
`define SPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sps assertion failed");

// clocked check, also live while in reset
`define SPS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sps assertion failed");

`else

`define SPS_ASSERT(lbl, clk, rst_n, prop)
`define SPS_ASSERT_NR(lbl, clk, prop)

`endif

`endif

### rtl/core/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared codes, types and helpers of the servo pulse phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    localparam int TIME_W = 32;
    localparam int DUR_W  = 16;
    localparam int ANG_W  = 16;
    localparam int OFS_W  = 19;   // sum of six 16-bit durations
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    // input operations
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_ACK    = 2'd2;
    localparam logic [1:0] MODE_CANCEL = 2'd3;

    // phase codes
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_POSACC   = 4'd1;
    localparam logic [3:0] PH_POSBRK   = 4'd2;
    localparam logic [3:0] PH_DWELL    = 4'd3;
    localparam logic [3:0] PH_NEGACC   = 4'd4;
    localparam logic [3:0] PH_NEGBRK   = 4'd5;
    localparam logic [3:0] PH_SETTLE   = 4'd6;
    localparam logic [3:0] PH_COMPLETE = 4'd7;
    localparam logic [3:0] PH_FAULT    = 4'd8;
    localparam logic [3:0] PH_CANCELED = 4'd9;

    // fault codes
    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_TIMEOUT = 2'd1;
    localparam logic [1:0] FAULT_LATE    = 2'd2;

    // register indexes
    localparam logic [2:0] REG_PULSE_DUR  = 3'd0;
    localparam logic [2:0] REG_ANGLE_OFS  = 3'd1;
    localparam logic [2:0] REG_DWELL      = 3'd2;
    localparam logic [2:0] REG_SETTLE     = 3'd3;
    localparam logic [2:0] REG_NEUTRAL    = 3'd4;
    localparam logic [2:0] REG_TIMEOUT    = 3'd5;
    localparam logic [2:0] REG_MAX_LATE   = 3'd6;

    // settings as the sequencer consumes them
    typedef struct packed {
        logic [7:0][OFS_W-1:0] dl_ofs;       // deadline offset of each phase
        logic [3:0][ANG_W-1:0] pulse_angle;  // neutral + offset, saturated
        logic [ANG_W-1:0]      neutral;
        logic [TIME_W-1:0]     timeout;
        logic [DUR_W-1:0]      max_late;
    } sps_cfg_t;

    typedef struct packed {
        logic [3:0]        phase;
        logic [1:0]        fault;
        logic [ANG_W-1:0]  angle;
        logic [TIME_W-1:0] elapsed;
        logic              active;
        logic              due;
    } sps_state_t;

    function automatic logic [ANG_W-1:0] sat_add16(input logic [ANG_W-1:0] a,
                                                   input logic [ANG_W-1:0] b);
        logic [ANG_W:0] s;
        s = {a[ANG_W-1], a} + {b[ANG_W-1], b};
        if (s[ANG_W] != s[ANG_W-1])
            return s[ANG_W] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
        return s[ANG_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/sps_in_if.sv
// ----------------------------------------------------------------------------
// sps_in_if
// Operation stream into the sequencer: mode and time stamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_in_if;
    import sps_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output mode, output now_ms, input ready);
    modport sink   (input valid, input mode, input now_ms, output ready);
endinterface

`default_nettype wire

### rtl/core/sps_out_if.sv
// ----------------------------------------------------------------------------
// sps_out_if
// Status stream out of the sequencer, one word per operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_out_if;
    import sps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [3:0]              phase_out;
    logic [1:0]              fault_out;
    logic signed [ANG_W-1:0] target_angle;
    logic [TIME_W-1:0]       elapsed_out;
    logic                    active_out;
    logic                    command_due_out;
    logic signed [ANG_W-1:0] start_angle;

    modport source (output valid, output phase_out, output fault_out,
                    output target_angle, output elapsed_out, output active_out,
                    output command_due_out, output start_angle, input ready);
    modport sink   (input valid, input phase_out, input fault_out,
                    input target_angle, input elapsed_out, input active_out,
                    input command_due_out, input start_angle, output ready);
endinterface

`default_nettype wire

### rtl/core/sps_cfg.sv
// ----------------------------------------------------------------------------
// sps_cfg
// APB register file plus the derived deadline offsets and pulse angles.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sps_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sps_pkg::DATA_W-1:0]  pwdata,
    output logic      [sps_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output sps_pkg::sps_cfg_t                cfg
);
    import sps_pkg::*;

    logic [DATA_W-1:0] pulse_dur_reg;
    logic [DATA_W-1:0] angle_ofs_reg;
    logic [DUR_W-1:0]  dwell_reg;
    logic [DUR_W-1:0]  settle_reg;
    logic [ANG_W-1:0]  neutral_reg;
    logic [TIME_W-1:0] timeout_reg;
    logic [DUR_W-1:0]  max_late_reg;
    sps_cfg_t          cfg_reg;
    sps_cfg_t          cfg_next;

    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_dur_reg <= '0;
            angle_ofs_reg <= '0;
            dwell_reg     <= '0;
            settle_reg    <= '0;
            neutral_reg   <= '0;
            timeout_reg   <= '0;
            max_late_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PULSE_DUR: pulse_dur_reg <= pwdata;
                REG_ANGLE_OFS: angle_ofs_reg <= pwdata;
                REG_DWELL:     dwell_reg     <= pwdata[DUR_W-1:0];
                REG_SETTLE:    settle_reg    <= pwdata[DUR_W-1:0];
                REG_NEUTRAL:   neutral_reg   <= pwdata[ANG_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata[TIME_W-1:0];
                REG_MAX_LATE:  max_late_reg  <= pwdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PULSE_DUR: prdata = pulse_dur_reg;
            REG_ANGLE_OFS: prdata = angle_ofs_reg;
            REG_DWELL:     prdata = DATA_W'(dwell_reg);
            REG_SETTLE:    prdata = DATA_W'(settle_reg);
            REG_NEUTRAL:   prdata = DATA_W'(neutral_reg);
            REG_TIMEOUT:   prdata = DATA_W'(timeout_reg);
            REG_MAX_LATE:  prdata = DATA_W'(max_late_reg);
            default:       prdata = '0;
        endcase
    end

    // deadline of phase p is start plus every phase duration before p
    always_comb
    begin
        cfg_next.dl_ofs[0] = '0;
        cfg_next.dl_ofs[1] = '0;
        cfg_next.dl_ofs[2] = OFS_W'(pulse_dur_reg[15:0]);
        cfg_next.dl_ofs[3] = cfg_next.dl_ofs[2] + OFS_W'(pulse_dur_reg[31:16]);
        cfg_next.dl_ofs[4] = cfg_next.dl_ofs[3] + OFS_W'(dwell_reg);
        cfg_next.dl_ofs[5] = cfg_next.dl_ofs[4] + OFS_W'(pulse_dur_reg[47:32]);
        cfg_next.dl_ofs[6] = cfg_next.dl_ofs[5] + OFS_W'(pulse_dur_reg[63:48]);
        cfg_next.dl_ofs[7] = cfg_next.dl_ofs[6] + OFS_W'(settle_reg);
        for (int k = 0; k < 4; k++)
            cfg_next.pulse_angle[k] = sat_add16(neutral_reg, angle_ofs_reg[16*k +: 16]);
        cfg_next.neutral  = neutral_reg;
        cfg_next.timeout  = timeout_reg;
        cfg_next.max_late = max_late_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/core/sps_seq.sv
// ----------------------------------------------------------------------------
// sps_seq
// Move state and its registered update for each operation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sps_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step_en,
    input  wire logic [1:0]                  mode,
    input  wire logic [sps_pkg::TIME_W-1:0]  now_ms,
    input  wire sps_pkg::sps_cfg_t           cfg,
    output sps_pkg::sps_state_t              st
);
    import sps_pkg::*;

    logic [TIME_W-1:0] start_time_reg, start_time_next;
    logic [TIME_W-1:0] cmd_dl_reg,     cmd_dl_next;
    logic [3:0]        phase_reg,      phase_next;
    logic [1:0]        fault_reg,      fault_next;
    logic [ANG_W-1:0]  angle_reg,      angle_next;
    logic [TIME_W-1:0] elapsed_reg,    elapsed_next;
    logic              active_reg,     active_next;
    logic              due_reg,        due_next;

    logic [3:0]        nxt_phase;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] fault_dl;
    logic [TIME_W-1:0] elapsed_now;
    logic              late_cmd;
    logic              late_end;
    logic [ANG_W-1:0]  nxt_angle;
    logic              do_fault;
    logic [1:0]        fault_code;
    logic              in_move;
    logic              start_step;
    logic              posacc_armed;

    assign nxt_phase   = phase_reg + 4'd1;
    assign end_time    = start_time_reg + TIME_W'(cfg.dl_ofs[nxt_phase[2:0]]);
    assign fault_dl    = start_time_reg + TIME_W'(cfg.dl_ofs[3'(PH_COMPLETE)]);
    assign elapsed_now = now_ms - start_time_reg;
    assign late_cmd    = (now_ms - cmd_dl_reg) > TIME_W'(cfg.max_late);
    assign late_end    = (now_ms - end_time) > TIME_W'(cfg.max_late);

    always_comb
    begin
        case (nxt_phase)
            PH_POSBRK: nxt_angle = cfg.pulse_angle[1];
            PH_NEGACC: nxt_angle = cfg.pulse_angle[2];
            PH_NEGBRK: nxt_angle = cfg.pulse_angle[3];
            default:   nxt_angle = cfg.neutral;
        endcase
    end

    always_comb
    begin
        start_time_next = start_time_reg;
        cmd_dl_next     = cmd_dl_reg;
        phase_next      = phase_reg;
        fault_next      = fault_reg;
        angle_next      = angle_reg;
        elapsed_next    = elapsed_reg;
        active_next     = active_reg;
        due_next        = due_reg;
        do_fault        = 1'b0;
        fault_code      = FAULT_NONE;

        case (mode)
            MODE_TICK:
            begin
                if (active_reg)
                begin
                    elapsed_next = elapsed_now;
                    if (elapsed_now >= cfg.timeout)
                    begin
                        do_fault   = 1'b1;
                        fault_code = FAULT_TIMEOUT;
                    end
                    else if (due_reg)
                    begin
                        do_fault   = late_cmd;
                        fault_code = FAULT_LATE;
                    end
                    else if (now_ms >= end_time)
                    begin
                        if (late_end)
                        begin
                            do_fault   = 1'b1;
                            fault_code = FAULT_LATE;
                        end
                        else if (phase_reg == PH_SETTLE)
                        begin
                            phase_next  = PH_COMPLETE;
                            active_next = 1'b0;
                            due_next    = 1'b0;
                            angle_next  = cfg.neutral;
                        end
                        else
                        begin
                            // advance to the next phase
                            phase_next  = nxt_phase;
                            due_next    = 1'b1;
                            cmd_dl_next = end_time;
                            angle_next  = nxt_angle;
                        end
                    end
                end
            end
            MODE_START:
            begin
                start_time_next = now_ms;
                elapsed_next    = '0;
                fault_next      = FAULT_NONE;
                active_next     = 1'b1;
                phase_next      = PH_POSACC;
                cmd_dl_next     = now_ms;
                angle_next      = cfg.pulse_angle[0];
                due_next        = 1'b0;
            end
            MODE_ACK:
            begin
                due_next = 1'b0;
            end
            MODE_CANCEL:
            begin
                phase_next  = PH_CANCELED;
                fault_next  = FAULT_NONE;
                angle_next  = cfg.neutral;
                active_next = 1'b0;
                due_next    = 1'b0;
            end
            default: ;
        endcase

        if (do_fault)
        begin
            fault_next  = fault_code;
            active_next = 1'b0;
            phase_next  = PH_FAULT;
            due_next    = 1'b1;
            cmd_dl_next = fault_dl;
            angle_next  = cfg.neutral;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            cmd_dl_reg     <= '0;
            phase_reg      <= PH_IDLE;
            fault_reg      <= FAULT_NONE;
            angle_reg      <= '0;
            elapsed_reg    <= '0;
            active_reg     <= 1'b0;
            due_reg        <= 1'b0;
        end
        else if (step_en)
        begin
            start_time_reg <= start_time_next;
            cmd_dl_reg     <= cmd_dl_next;
            phase_reg      <= phase_next;
            fault_reg      <= fault_next;
            angle_reg      <= angle_next;
            elapsed_reg    <= elapsed_next;
            active_reg     <= active_next;
            due_reg        <= due_next;
        end
    end

    assign st.phase   = phase_reg;
    assign st.fault   = fault_reg;
    assign st.angle   = angle_reg;
    assign st.elapsed = elapsed_reg;
    assign st.active  = active_reg;
    assign st.due     = due_reg;

    assign in_move      = (phase_reg >= PH_POSACC) && (phase_reg <= PH_SETTLE);
    assign start_step   = step_en && (mode == MODE_START);
    assign posacc_armed = active_reg && !due_reg && (phase_reg == PH_POSACC);

    `SPS_ASSERT(a_active_in_move, clk, rst_n, active_reg |-> in_move)
    `SPS_ASSERT(a_fault_phase, clk, rst_n, (fault_reg != FAULT_NONE) == (phase_reg == PH_FAULT))
    `SPS_ASSERT(a_start_arms, clk, rst_n, start_step |=> posacc_armed)
    `SPS_ASSERT_NR(a_reset_quiet, clk, !rst_n |-> (!active_reg && !due_reg))

endmodule

`default_nettype wire

### rtl/core/servo_pulse_phase_sequencer_unit.sv
// ----------------------------------------------------------------------------
// servo_pulse_phase_sequencer_unit
// Open-loop servo move sequencer: operation register, state update, status out.
// ----------------------------------------------------------------------------
//  port     dir   kind        carries
//  in_ch    in    valid/ready mode, now_ms
//  out_ch   out   valid/ready phase, fault, angles, elapsed, flags
//  apb      in    APB write   seven settings at byte address 8*i
//
//  One operation per cycle while out_ch is not stalled; each taken operation
//  passes the operation register, then the state update into status registers.
//  The state registers double as the output word, so a stalled output holds
//  the state and the operation register; in_ch.ready stays high while either
//  of them can move. Reset clears all state but the held mode and time; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_pulse_phase_sequencer_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sps_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sps_pkg::DATA_W-1:0]  pwdata,
    output logic      [sps_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    sps_in_if.sink                           in_ch,
    sps_out_if.source                        out_ch
);
    import sps_pkg::*;

    sps_cfg_t   cfg;
    sps_state_t st;

    logic              in_valid_reg, in_valid_next;
    logic [1:0]        mode_reg;
    logic [TIME_W-1:0] now_reg;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              step_en;
    logic              in_take;

    sps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sps_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .mode    (mode_reg),
        .now_ms  (now_reg),
        .cfg     (cfg),
        .st      (st)
    );

    assign advance     = !out_valid_reg || out_ch.ready;
    assign step_en     = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    assign in_valid_next  = in_take ? 1'b1 : (step_en ? 1'b0 : in_valid_reg);
    assign out_valid_next = step_en ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the operation until the state update takes it
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg <= in_ch.mode;
            now_reg  <= in_ch.now_ms;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.phase_out       = st.phase;
    assign out_ch.fault_out       = st.fault;
    assign out_ch.target_angle    = st.angle;
    assign out_ch.elapsed_out     = st.elapsed;
    assign out_ch.active_out      = st.active;
    assign out_ch.command_due_out = st.due;
    assign out_ch.start_angle     = cfg.pulse_angle[0];

endmodule

`default_nettype wire
